>>> rtl/mtf_pkg.sv
`default_nettype none
package mtf_pkg;
  localparam logic [1:0] CMD_GET   = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] lookup_hash;
    logic [31:0] write_value;
    logic        write_live;
  } mtf_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
  } mtf_out_t;
endpackage
`default_nettype wire

>>> rtl/mtf_ram.sv
`default_nettype none
module mtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/move_to_front_hash_map_core.sv
`default_nettype none
// Move-to-front keyed table, one command at a time.
// Each scanned list position takes an order read, a slot read and a compare;
// a get hit then shifts up to ENTRIES-1 order entries down by one and puts
// the hit slot at the front of the list.
// No output stall: busy stays high through the strobe, next accept in the cycle after it.
// Reset clears live marks, entry count and control; memories are left as is.
module move_to_front_hash_map_core #(
  parameter int ENTRIES    = 16,
  parameter int HASH_BITS  = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire mtf_pkg::mtf_in_t in_item,
  output logic                out_valid,
  output mtf_pkg::mtf_out_t   out_item
);
  import mtf_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SW = HASH_BITS + VALUE_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ORD   = 3'd1;
  localparam logic [2:0] S_SLOT  = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_SHW   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]            state_r, state_nxt;
  logic [1:0]            cmd_r;
  logic [HASH_BITS-1:0]  hash_r;
  logic [VALUE_BITS-1:0] val_r;
  logic                  wlive_r;
  logic [CW-1:0]         pos_r, pos_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [AW-1:0]         slot_r, slot_nxt;
  logic [ENTRIES-1:0]    live_r, live_nxt;
  logic [1:0]            st_r, st_nxt;
  logic [31:0]           rv_r, rv_nxt;

  // order memory
  logic          o_we;
  logic [AW-1:0] o_wa, o_wd, o_ra, o_rd;
  // slot memory: {hash, value}
  logic          s_we;
  logic [AW-1:0] s_wa, s_ra;
  logic [SW-1:0] s_wd, s_rd;

  mtf_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_order (
    .clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));
  mtf_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_slot (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

  logic [HASH_BITS-1:0]  rd_hash;
  logic [VALUE_BITS-1:0] rd_val;
  logic                  rd_live, hit;
  assign rd_hash = s_rd[SW-1:VALUE_BITS];
  assign rd_val  = s_rd[VALUE_BITS-1:0];
  assign rd_live = live_r[slot_r];
  assign hit = (cmd_r == CMD_GET) ? (rd_live && rd_hash == hash_r)
                                  : (rd_hash == hash_r || !rd_live);

  always_comb begin
    state_nxt = state_r;
    pos_nxt = pos_r;
    cnt_nxt = cnt_r;
    slot_nxt = slot_r;
    live_nxt = live_r;
    st_nxt = st_r;
    rv_nxt = rv_r;
    o_we = 1'b0; o_wa = pos_r[AW-1:0]; o_wd = slot_r;
    o_ra = pos_r[AW-1:0];
    s_we = 1'b0; s_wa = slot_r; s_ra = o_rd;
    s_wd = {hash_r, val_r};
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          pos_nxt = '0;
          st_nxt = ST_OK;
          rv_nxt = '0;
          state_nxt = (in_item.cmd == CMD_NOP) ? S_DONE : S_ORD;
        end
      end
      // order read issued for pos_r; wait data
      S_ORD: begin
        if (pos_r >= cnt_r) begin
          priority case (cmd_r)
            CMD_GET: begin st_nxt = ST_MISS; state_nxt = S_DONE; end
            CMD_SET: begin
              if (cnt_r == CW'(ENTRIES)) begin
                st_nxt = ST_FULL;
                state_nxt = S_DONE;
              end else begin
                // append: order[cnt]=cnt, slot gets hash; live with value if write_live, else empty
                o_we = 1'b1; o_wa = cnt_r[AW-1:0]; o_wd = cnt_r[AW-1:0];
                slot_nxt = cnt_r[AW-1:0];
                cnt_nxt = cnt_r + CW'(1);
                if (wlive_r) begin
                  s_we = 1'b1; s_wa = cnt_r[AW-1:0];
                  live_nxt[cnt_r[AW-1:0]] = 1'b1;
                end else begin
                  s_we = 1'b1; s_wa = cnt_r[AW-1:0]; s_wd = {hash_r, VALUE_BITS'(0)};
                  live_nxt[cnt_r[AW-1:0]] = 1'b0;
                end
                state_nxt = S_DONE;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end else begin
          state_nxt = S_SLOT;
        end
      end
      // order data valid: issue slot read
      S_SLOT: begin
        s_ra = o_rd;
        slot_nxt = o_rd;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (cmd_r == CMD_CLEAR) begin
          s_we = 1'b1; s_wd = {HASH_BITS'(0), rd_val};
          live_nxt[slot_r] = 1'b0;
          pos_nxt = pos_r + CW'(1);
          state_nxt = S_ORD;
        end else if (!hit) begin
          pos_nxt = pos_r + CW'(1);
          state_nxt = S_ORD;
        end else if (cmd_r == CMD_GET) begin
          rv_nxt = 32'(rd_val);
          state_nxt = S_SHIFT;
          pos_nxt = pos_r;
          o_ra = pos_r[AW-1:0] - AW'(1);
          if (pos_r == '0) begin
            state_nxt = S_SHW;
          end
        end else begin
          if (!(rd_live == wlive_r && (!wlive_r || rd_val == val_r))) begin
            s_we = 1'b1;
            live_nxt[slot_r] = wlive_r;
          end
          state_nxt = S_DONE;
        end
      end
      // order[pos-1] read issued last cycle; write it to pos, step down
      S_SHIFT: begin
        o_we = 1'b1; o_wd = o_rd;
        pos_nxt = pos_r - CW'(1);
        o_ra = pos_r[AW-1:0] - AW'(2);
        if (pos_r == CW'(1)) state_nxt = S_SHW;
      end
      S_SHW: begin
        o_we = 1'b1; o_wa = '0; o_wd = slot_r;
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      live_r <= '0;
      pos_r <= '0;
      st_r <= ST_OK;
      rv_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      live_r <= live_nxt;
      pos_r <= pos_nxt;
      st_r <= st_nxt;
      rv_r <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    if (state_r == S_IDLE && start) begin
      cmd_r   <= in_item.cmd;
      hash_r  <= HASH_BITS'(in_item.lookup_hash);
      val_r   <= VALUE_BITS'(in_item.write_value);
      wlive_r <= in_item.write_live;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_item.status = st_r;
  assign out_item.read_value = rv_r;

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CW'(ENTRIES))
    else $error("entry count overflow");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |=> $stable(cnt_r))
    else $error("count changed while idle");
  a_rv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_OK) |-> out_item.read_value == '0)
    else $error("nonzero value on miss");
endmodule
`default_nettype wire

>>> verif/mtf_checker.sv
`timescale 1ns / 1ps
module mtf_checker (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire                busy,
  input  mtf_pkg::mtf_in_t   in_item,
  input  wire                out_valid,
  input  mtf_pkg::mtf_out_t  out_item,
  output int                 fail_count,
  output int                 pending_count,
  output int                 hit_count,
  output int                 full_count
);
  import mtf_pkg::*;

  localparam int ENTRIES = 16;

  // shadow copy of the table
  logic [31:0] tbl_hash [ENTRIES];
  logic [31:0] tbl_value [ENTRIES];
  logic        tbl_live [ENTRIES];
  logic [3:0]  list_slot [ENTRIES];
  int          used_slots;

  mtf_out_t answer_q[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // apply one command to the shadow table and return its answer
  function automatic mtf_out_t table_apply(input mtf_in_t it);
    mtf_out_t r;
    int p;
    int s;
    bit found;
    r.status = ST_OK;
    r.read_value = '0;
    s = 0;
    found = 0;
    case (it.cmd)
      CMD_GET: begin
        for (p = 0; p < used_slots; p++) begin
          s = list_slot[p];
          if (tbl_live[s] && tbl_hash[s] == it.lookup_hash) begin
            found = 1;
            break;
          end
        end
        if (!found) r.status = ST_MISS;
        else begin
          for (; p > 0; p--) list_slot[p] = list_slot[p-1];
          list_slot[0] = s[3:0];
          r.read_value = tbl_value[s];
        end
      end
      CMD_SET: begin
        for (p = 0; p < used_slots; p++) begin
          s = list_slot[p];
          if (tbl_hash[s] == it.lookup_hash || !tbl_live[s]) begin
            found = 1;
            break;
          end
        end
        if (!found && used_slots >= ENTRIES) r.status = ST_FULL;
        else begin
          if (!found) begin
            s = used_slots;
            list_slot[used_slots] = s[3:0];
            tbl_hash[s] = it.lookup_hash;
            tbl_value[s] = '0;
            tbl_live[s] = 0;
            used_slots++;
          end
          if (!(tbl_live[s] == it.write_live &&
                (!it.write_live || tbl_value[s] == it.write_value))) begin
            tbl_hash[s] = it.lookup_hash;
            tbl_value[s] = it.write_value;
            tbl_live[s] = it.write_live;
          end
        end
      end
      CMD_CLEAR: begin
        for (p = 0; p < used_slots; p++) begin
          tbl_hash[list_slot[p]] = '0;
          tbl_live[list_slot[p]] = 0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending_count = answer_q.size();

  always @(posedge clk) begin
    mtf_out_t want;
    if (!rst_n) begin
      used_slots = 0;
      for (int i = 0; i < ENTRIES; i++) tbl_live[i] = 0;
      answer_q.delete();
    end else begin
      if (start && !busy) begin
        want = table_apply(in_item);
        if (in_item.cmd == CMD_GET && want.status == ST_OK) hit_count++;
        if (want.status == ST_FULL) full_count++;
        answer_q.push_back(want);
      end
      if (out_valid) begin
        if (answer_q.size() == 0) begin
          report_mismatch("unexpected result", out_item.read_value, 32'h0);
        end else begin
          want = answer_q.pop_front();
          if (out_item.status !== want.status)
            report_mismatch("status", 32'(out_item.status), 32'(want.status));
          if (out_item.read_value !== want.read_value)
            report_mismatch("read_value", out_item.read_value, want.read_value);
        end
      end
    end
  end
endmodule

>>> verif/tb_move_to_front_hash_map_core.sv
`timescale 1ns / 1ps
module tb_move_to_front_hash_map_core;
  import mtf_pkg::*;

  localparam int RANDOM_ITEMS = 1900;
  localparam int STALL_LIMIT  = 5000;

  logic     clk = 0;
  logic     rst_n = 0;
  logic     start = 0;
  logic     busy;
  mtf_in_t  in_item = '0;
  logic     out_valid;
  mtf_out_t out_item;
  int       fail_count, pending_count, hit_count, full_count;
  int       idle_cycles = 0;
  int       sent = 0;
  logic [31:0] key_pool [8];

  always #10 clk = ~clk;

  move_to_front_hash_map_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  mtf_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .fail_count(fail_count),
    .pending_count(pending_count), .hit_count(hit_count), .full_count(full_count)
  );

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // send one item, then idle a random gap
  task automatic send_item(input logic [1:0] c, input logic [31:0] h,
                           input logic [31:0] v, input logic l);
    int gap;
    @(posedge clk);
    start <= 1'b1;
    in_item <= '{cmd: c, lookup_hash: h, write_value: v, write_live: l};
    do @(posedge clk); while (busy);
    sent++;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
          ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 4));
    // drop start; the next send_item raises it again at its first edge
    start <= 1'b0;
    if (gap > 1) repeat (gap - 1) @(posedge clk);
  endtask

  initial begin
    int c;
    logic [31:0] h;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;

    // directed: misses on empty table, extremes, same-value, empties, full
    send_item(CMD_GET, 32'h0, 32'h0, 1'b0);
    send_item(CMD_SET, 32'h0, 32'hFFFF_FFFF, 1'b1);
    send_item(CMD_SET, 32'hFFFF_FFFF, 32'h0, 1'b1);
    send_item(CMD_GET, 32'hFFFF_FFFF, 32'h0, 1'b0);
    send_item(CMD_SET, 32'hFFFF_FFFF, 32'h0, 1'b1);
    send_item(CMD_SET, 32'h0, 32'h0, 1'b0);
    send_item(CMD_GET, 32'h0, 32'h0, 1'b0);
    send_item(CMD_SET, 32'h5555_AAAA, 32'h1234, 1'b0);
    send_item(CMD_SET, 32'h0, 32'hAAAA_5555, 1'b1);
    send_item(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    for (int i = 0; i < 17; i++)
      send_item(CMD_SET, 32'h100 + i, i, 1'b1);
    send_item(CMD_GET, 32'h10F, 32'h0, 1'b0);
    send_item(CMD_CLEAR, 32'h0, 32'h0, 1'b0);
    send_item(CMD_GET, 32'h101, 32'h0, 1'b0);

    // random: mostly pooled keys so hits, moves and refills happen
    while (sent < RANDOM_ITEMS + 32) begin
      c = $urandom_range(0, 99);
      h = ($urandom_range(0, 4) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
      if (c < 45)      send_item(CMD_GET, h, $urandom(), 1'($urandom_range(0, 1)));
      else if (c < 94) send_item(CMD_SET, h, ($urandom_range(0, 3) == 0) ?
                                 32'(h[1:0]) : $urandom(), $urandom_range(0, 4) != 0);
      else if (c < 97) send_item(CMD_CLEAR, $urandom(), $urandom(),
                                 1'($urandom_range(0, 1)));
      else             send_item(CMD_NOP, $urandom(), $urandom(),
                                 1'($urandom_range(0, 1)));
    end

    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d items: gets, sets, soft resets and unused commands", sent);
    $display("Get hits %0d, sets dropped on full table %0d", hit_count, full_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
